@@ hdl/bfd_pkg.sv @@
package bfd_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_FACTOR = 8;

    localparam int CH_W        = 8;
    localparam int NUM_LANES   = 4;
    localparam int FACTOR_W    = 4;
    localparam int SRC_WIDTH_W = 13;
    localparam int OUT_COL_W   = 12;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FACTOR       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = CFG_IDX_W'(1);

    localparam logic [FACTOR_W-1:0]    FACTOR_RESET    = FACTOR_W'(2);
    localparam logic [SRC_WIDTH_W-1:0] SRC_WIDTH_RESET = SRC_WIDTH_W'(4096);

    typedef logic [CH_W-1:0] chan_t;

    typedef enum logic [1:0] {
        ST_START,
        ST_DIV_WIDTH,
        ST_DIV_COLUMN,
        ST_RUN
    } ctrl_state_t;

    typedef struct packed {
        logic acc;
        logic byp;
        logic fresh;
        logic we;
        logic prod_load;
    } lane_ctl_t;

    typedef struct packed {
        logic                 load;
        logic                 valid;
        logic                 row_end;
        logic [OUT_COL_W-1:0] column;
    } merge_ctl_t;

endpackage

@@ hdl/bfd_if.sv @@
interface bfd_pix_in_if import bfd_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  frame_start;
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
    chan_t alpha_in;

    modport source (
        output valid, frame_start, red_in, green_in, blue_in, alpha_in,
        input  ready
    );
    modport sink (
        input  valid, frame_start, red_in, green_in, blue_in, alpha_in,
        output ready
    );
endinterface

interface bfd_pix_out_if import bfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    chan_t                red_out;
    chan_t                green_out;
    chan_t                blue_out;
    chan_t                alpha_out;
    logic [OUT_COL_W-1:0] out_column;
    logic                 row_end;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out, out_column, row_end,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out, out_column, row_end,
        output ready
    );
endinterface

interface bfd_cfg_if import bfd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ hdl/bfd_ctrl.sv @@
module bfd_ctrl
    import bfd_pkg::*;
#(
    parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int  MAX_FACTOR = DEF_MAX_FACTOR,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int WW         = $clog2(MAX_WIDTH) + 1,
    localparam int FW         = $clog2(MAX_FACTOR + 1),
    localparam int RW         = $clog2(MAX_FACTOR),
    localparam int CNW        = $clog2(WW)
)
(
    input  logic              clk,
    input  logic              rst_n,
    bfd_pix_in_if.sink        pix_in,
    bfd_cfg_if.sink           cfg,
    input  logic              out_ready,
    output lane_ctl_t         lane_ctl,
    output logic [CW-1:0]     rd_addr,
    output logic [CW-1:0]     wr_addr,
    output logic [FW-1:0]     eff_factor,
    output merge_ctl_t        merge_ctl
);

    ctrl_state_t            state_reg, state_next;
    logic [FACTOR_W-1:0]    factor_reg, factor_next;
    logic [SRC_WIDTH_W-1:0] width_reg, width_next;
    logic [CW-1:0]          col_reg, col_next;
    logic [RW-1:0]          row_reg, row_next;
    logic [RW-1:0]          cib_reg, cib_next;
    logic [CW-1:0]          oc_reg, oc_next;
    logic [WW-1:0]          blocks_reg, blocks_next;
    logic [WW-1:0]          dvd_reg, dvd_next;
    logic [FW-1:0]          rem_reg, rem_next;
    logic [CNW-1:0]         cnt_reg, cnt_next;

    logic                   s1_v_reg, s1_v_next;
    logic                   s1_fresh_reg;
    logic                   s1_wr_reg;
    logic                   s1_emit_reg;
    logic                   s1_row_end_reg;
    logic [CW-1:0]          s1_addr_reg;
    logic [OUT_COL_W-1:0]   s1_col_reg;
    logic                   s2_v_reg, s2_v_next;
    logic                   s2_row_end_reg;
    logic [OUT_COL_W-1:0]   s2_col_reg;
    logic                   out_v_reg, out_v_next;

    logic [WW-1:0]          eff_w;
    logic [FW-1:0]          eff_f;

    logic [CW-1:0]          oc0, oc1;
    logic [FW-1:0]          row0, row1, cib0, cib1;
    logic [WW-1:0]          col1;
    logic                   in_block, fresh, last, emit, row_end;

    logic [FW:0]            rem_sh;
    logic                   ge;
    logic [FW-1:0]          rem_new;
    logic [WW-1:0]          dvd_new;

    logic                   out_free, s2_leave, s2_free, s1_leave, s2_load, s1_free;
    logic                   in_ready, acc;

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(width_reg);
        end

        if (factor_reg == '0)
        begin
            eff_f = FW'(1);
        end
        else if (int'(factor_reg) > MAX_FACTOR)
        begin
            eff_f = FW'(MAX_FACTOR);
        end
        else
        begin
            eff_f = FW'(factor_reg);
        end
    end

    // position of the arriving pixel and position after it
    always_comb
    begin
        row0 = FW'(row_reg);
        cib0 = FW'(cib_reg);
        oc0  = oc_reg;
        col1 = WW'(col_reg) + WW'(1);
        if (pix_in.frame_start)
        begin
            row0 = '0;
            cib0 = '0;
            oc0  = '0;
            col1 = WW'(1);
        end
        else if (WW'(col_reg) >= eff_w)
        begin
            row0 = row0 + FW'(1);
            cib0 = '0;
            oc0  = '0;
            col1 = WW'(1);
        end
        if (row0 >= eff_f)
        begin
            row0 = '0;
        end

        in_block = WW'(oc0) < blocks_reg;
        fresh    = (row0 == '0) && (cib0 == '0);
        last     = (row0 == eff_f - FW'(1)) && (cib0 == eff_f - FW'(1));
        emit     = in_block && last;
        row_end  = WW'(oc0) == blocks_reg - WW'(1);

        row1 = row0;
        cib1 = cib0 + FW'(1);
        oc1  = oc0;
        if (cib1 == eff_f)
        begin
            cib1 = '0;
            oc1  = oc0 + CW'(1);
        end
        if (col1 >= eff_w)
        begin
            col1 = '0;
            row1 = row0 + FW'(1);
            cib1 = '0;
            oc1  = '0;
            if (row1 >= eff_f)
            begin
                row1 = '0;
            end
        end
    end

    // one restoring division step per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[WW-1]};
        ge      = rem_sh >= {1'b0, eff_f};
        rem_new = ge ? FW'(rem_sh - {1'b0, eff_f}) : FW'(rem_sh);
        dvd_new = {dvd_reg[WW-2:0], ge};
    end

    always_comb
    begin
        out_free = !out_v_reg || out_ready;
        s2_leave = s2_v_reg && out_free;
        s2_free  = !s2_v_reg || out_free;
        s1_leave = s1_v_reg && (!s1_emit_reg || s2_free);
        s2_load  = s1_leave && s1_emit_reg;
        s1_free  = !s1_v_reg || s1_leave;
        in_ready = (state_reg == ST_RUN) && s1_free;
        acc      = pix_in.valid && in_ready;
    end

    always_comb
    begin
        state_next  = state_reg;
        factor_next = factor_reg;
        width_next  = width_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        cib_next    = cib_reg;
        oc_next     = oc_reg;
        blocks_next = blocks_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;

        case (state_reg)
            ST_START:
            begin
                dvd_next   = eff_w;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV_WIDTH;
            end
            ST_DIV_WIDTH:
            begin
                dvd_next = dvd_new;
                rem_next = rem_new;
                cnt_next = cnt_reg + CNW'(1);
                if (cnt_reg == CNW'(WW - 1))
                begin
                    blocks_next = dvd_new;
                    dvd_next    = WW'(col_reg);
                    rem_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_DIV_COLUMN;
                end
            end
            ST_DIV_COLUMN:
            begin
                dvd_next = dvd_new;
                rem_next = rem_new;
                cnt_next = cnt_reg + CNW'(1);
                if (cnt_reg == CNW'(WW - 1))
                begin
                    oc_next    = CW'(dvd_new);
                    cib_next   = RW'(rem_new);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (acc)
                begin
                    col_next = CW'(col1);
                    row_next = RW'(row1);
                    cib_next = RW'(cib1);
                    oc_next  = oc1;
                end
            end
            default:
            begin
                state_next = ST_START;
            end
        endcase

        if (cfg.valid)
        begin
            state_next = ST_START;
            case (cfg.index)
                REG_FACTOR:       factor_next = cfg.data[FACTOR_W-1:0];
                REG_SOURCE_WIDTH: width_next  = cfg.data[SRC_WIDTH_W-1:0];
                default:          ;
            endcase
        end

        s1_v_next  = acc ? 1'b1 : (s1_leave ? 1'b0 : s1_v_reg);
        s2_v_next  = s2_load ? 1'b1 : (s2_leave ? 1'b0 : s2_v_reg);
        out_v_next = s2_leave ? 1'b1 : (out_ready ? 1'b0 : out_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_START;
            factor_reg <= FACTOR_RESET;
            width_reg  <= SRC_WIDTH_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            cib_reg    <= '0;
            oc_reg     <= '0;
            blocks_reg <= '0;
            dvd_reg    <= '0;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            factor_reg <= factor_next;
            width_reg  <= width_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            cib_reg    <= cib_next;
            oc_reg     <= oc_next;
            blocks_reg <= blocks_next;
            dvd_reg    <= dvd_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
            s1_v_reg   <= s1_v_next;
            s2_v_reg   <= s2_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_fresh_reg   <= fresh;
            s1_wr_reg      <= in_block;
            s1_emit_reg    <= emit;
            s1_row_end_reg <= row_end;
            s1_addr_reg    <= oc0;
            s1_col_reg     <= OUT_COL_W'(oc0);
        end
        if (s2_load)
        begin
            s2_row_end_reg <= s1_row_end_reg;
            s2_col_reg     <= s1_col_reg;
        end
    end

    assign pix_in.ready = in_ready;
    assign cfg.ready    = 1'b1;

    // item in the sum stage writes the same column this cycle
    assign lane_ctl.acc       = acc;
    assign lane_ctl.byp       = s1_v_reg && s1_wr_reg && s1_leave && (s1_addr_reg == oc0);
    assign lane_ctl.fresh     = s1_fresh_reg;
    assign lane_ctl.we        = s1_leave && s1_wr_reg;
    assign lane_ctl.prod_load = s2_load;

    assign rd_addr    = oc0;
    assign wr_addr    = s1_addr_reg;
    assign eff_factor = eff_f;

    assign merge_ctl.load    = s2_leave;
    assign merge_ctl.valid   = out_v_reg;
    assign merge_ctl.row_end = s2_row_end_reg;
    assign merge_ctl.column  = s2_col_reg;

endmodule

@@ hdl/bfd_lane.sv @@
module bfd_lane
    import bfd_pkg::*;
#(
    parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int  MAX_FACTOR = DEF_MAX_FACTOR,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int FW         = $clog2(MAX_FACTOR + 1),
    localparam int SW         = $clog2(2 * MAX_FACTOR * MAX_FACTOR * 255),
    localparam int LD         = $clog2(MAX_FACTOR * MAX_FACTOR),
    localparam int K          = SW + LD,
    localparam int MW         = K + 1,
    localparam int PW         = SW + MW
)
(
    input  logic          clk,
    input  lane_ctl_t     ctl,
    input  logic [CW-1:0] rd_addr,
    input  logic [CW-1:0] wr_addr,
    input  logic [FW-1:0] eff_factor,
    input  chan_t         pix,
    output chan_t         quo
);

    logic [SW-1:0] mem [MAX_WIDTH];
    logic [SW-1:0] rd_reg;
    logic [SW-1:0] byp_data_reg;
    logic          byp_reg;
    chan_t         px_reg;
    logic [SW-1:0] operand;
    logic [SW-1:0] sum;
    logic [PW-1:0] prod_reg;
    logic [MW-1:0] recip_tab [MAX_FACTOR + 1];
    logic [MW-1:0] recip;

    // ceil(2^K / f^2): exact floor division for every sum that fits SW bits
    for (genvar g = 0; g <= MAX_FACTOR; g++)
    begin : g_recip
        localparam longint unsigned DIVISOR = (g == 0) ? 1 : g * g;
        localparam longint unsigned RECIP   = ((64'd1 << K) + DIVISOR - 1) / DIVISOR;
        assign recip_tab[g] = MW'(RECIP);
    end

    assign recip   = recip_tab[eff_factor];
    assign operand = byp_reg ? byp_data_reg : rd_reg;
    assign sum     = ctl.fresh ? SW'(px_reg) : operand + SW'(px_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.acc)
        begin
            rd_reg       <= mem[rd_addr];
            px_reg       <= pix;
            byp_reg      <= ctl.byp;
            byp_data_reg <= sum;
        end
        if (ctl.we)
        begin
            mem[wr_addr] <= sum;
        end
        if (ctl.prod_load)
        begin
            prod_reg <= PW'(sum) * PW'(recip);
        end
    end

    assign quo = prod_reg[K +: CH_W];

endmodule

@@ hdl/bfd_merge.sv @@
module bfd_merge
    import bfd_pkg::*;
(
    input  logic           clk,
    input  merge_ctl_t     ctl,
    input  chan_t          quo [NUM_LANES],
    bfd_pix_out_if.source  pix_out
);

    chan_t                ch_reg [NUM_LANES];
    logic [OUT_COL_W-1:0] column_reg;
    logic                 row_end_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                ch_reg[i] <= quo[i];
            end
            column_reg  <= ctl.column;
            row_end_reg <= ctl.row_end;
        end
    end

    assign pix_out.valid      = ctl.valid;
    assign pix_out.red_out    = ch_reg[0];
    assign pix_out.green_out  = ch_reg[1];
    assign pix_out.blue_out   = ch_reg[2];
    assign pix_out.alpha_out  = ch_reg[3];
    assign pix_out.out_column = column_reg;
    assign pix_out.row_end    = row_end_reg;

endmodule

@@ hdl/box_filter_downsampler_top.sv @@
// box filter downsampler: four channel lanes with column sum line stores, one shared control path
// throughput: one pixel per cycle while not recomputing and while the output takes results, set by the
// read-modify-write of the line store per lane; a closing pixel passes the sum stage, the product register
// and the output register before its result is valid. After reset and after every configuration write,
// two serial divisions refresh block count and column position; no pixel is taken meanwhile
// reset: asynchronous active low, clears counters, factor to 2, width to 4096; sums not cleared
module box_filter_downsampler_top
    import bfd_pkg::*;
#(
    parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int  MAX_FACTOR = DEF_MAX_FACTOR,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int FW         = $clog2(MAX_FACTOR + 1)
)
(
    input  logic           clk,
    input  logic           rst_n,
    bfd_pix_in_if.sink     pix_in,
    bfd_pix_out_if.source  pix_out,
    bfd_cfg_if.sink        cfg
);

    lane_ctl_t     lane_ctl;
    merge_ctl_t    merge_ctl;
    logic [CW-1:0] rd_addr;
    logic [CW-1:0] wr_addr;
    logic [FW-1:0] eff_factor;
    chan_t         pix_ch [NUM_LANES];
    chan_t         quo [NUM_LANES];

    assign pix_ch[0] = pix_in.red_in;
    assign pix_ch[1] = pix_in.green_in;
    assign pix_ch[2] = pix_in.blue_in;
    assign pix_ch[3] = pix_in.alpha_in;

    bfd_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .cfg        (cfg),
        .out_ready  (pix_out.ready),
        .lane_ctl   (lane_ctl),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .eff_factor (eff_factor),
        .merge_ctl  (merge_ctl)
    );

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        bfd_lane #(
            .MAX_WIDTH  (MAX_WIDTH),
            .MAX_FACTOR (MAX_FACTOR)
        ) u_lane (
            .clk        (clk),
            .ctl        (lane_ctl),
            .rd_addr    (rd_addr),
            .wr_addr    (wr_addr),
            .eff_factor (eff_factor),
            .pix        (pix_ch[i]),
            .quo        (quo[i])
        );
    end

    bfd_merge u_merge (
        .clk     (clk),
        .ctl     (merge_ctl),
        .quo     (quo),
        .pix_out (pix_out)
    );

endmodule

@@ hdl/bfd_checker.sv @@
module bfd_checker
    import bfd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input chan_t                red_out,
    input chan_t                green_out,
    input chan_t                blue_out,
    input chan_t                alpha_out,
    input logic [OUT_COL_W-1:0] out_column,
    input logic                 row_end
);

    // no pixel taken while reset holds, and nothing offered
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !in_ready && !out_valid)
        else $error("pixel port ready or output valid during reset");

    // a configuration write starts the recompute, which blocks input
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("input ready right after a configuration write");

    // input stays blocked also in the cycle after the one checked above
    a_cfg_blocks_two: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> ##1 !in_ready)
        else $error("input ready two cycles after a configuration write");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(alpha_out) && $stable(out_column)
            && $stable(row_end))
        else $error("stalled output item changed");

    // no pixel taken right after a configuration write
    a_no_input_during_block: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !$past(cfg_valid && cfg_ready))
        else $error("pixel taken right after a configuration write");

endmodule

bind box_filter_downsampler_top bfd_checker u_bfd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pix_in.valid),
    .in_ready   (pix_in.ready),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .out_valid  (pix_out.valid),
    .out_ready  (pix_out.ready),
    .red_out    (pix_out.red_out),
    .green_out  (pix_out.green_out),
    .blue_out   (pix_out.blue_out),
    .alpha_out  (pix_out.alpha_out),
    .out_column (pix_out.out_column),
    .row_end    (pix_out.row_end)
);
